[hw/rtl/dib_pixel_to_argb_macros.svh]
// Assertion macros for the checker of the pixel-to-ARGB block.
// No dependencies; files that assert pull this header in by name.
`ifndef DIB_PIXEL_TO_ARGB_MACROS_SVH
`define DIB_PIXEL_TO_ARGB_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define DPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DPA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/dpa_pkg.sv]
// Shared types, codes and constants for the pixel-to-ARGB block.
// No dependencies; used by the input interface, the top level and the checker.
`default_nettype none

package dpa_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] PAL_SIZE = 9'(PALETTE_DEPTH);

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [2:0] RST_PIXEL_DEPTH     = 3'd2;
  localparam logic       RST_ALPHA_FROM_DATA = 1'b0;
  localparam logic [8:0] RST_PALETTE_ENTRIES = 9'd256;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [3:0] NIBBLE_MASK  = 4'hF;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    DEPTH_1BPP  = 3'd0,
    DEPTH_4BPP  = 3'd1,
    DEPTH_8BPP  = 3'd2,
    DEPTH_24BPP = 3'd3,
    DEPTH_32BPP = 3'd4
  } pix_depth_t;

  typedef enum logic [1:0] {
    REG_PIXEL_DEPTH     = 2'd0,
    REG_ALPHA_FROM_DATA = 2'd1,
    REG_PALETTE_ENTRIES = 2'd2
  } cfg_reg_t;

  // Palette entries actually in use for a table of full_sz entries.
  function automatic logic [8:0] used_size(input logic [8:0] entries,
                                           input logic [8:0] full_sz);
    logic [8:0] n;
    n = entries;
    if (n == 9'd0 || n > full_sz) n = full_sz;
    if (n > PAL_SIZE) n = PAL_SIZE;
    return n;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dpa_in_if.sv]
// Input channel: valid/ready handshake carrying one load or pixel transaction.
// Depends on dpa_pkg.
`default_nettype none

interface dpa_in_if;
  import dpa_pkg::*;

  logic        valid;
  logic        ready;
  action_t     action;
  logic [7:0]  entry_index;
  logic [31:0] pixel_data;
  logic [2:0]  bit_position;
  logic        mask_bit;

  modport source (
    output valid, action, entry_index, pixel_data, bit_position, mask_bit,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, pixel_data, bit_position, mask_bit,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/dpa_out_if.sv]
// Result channel: valid/ready handshake carrying one ARGB8888 pixel.
// No dependencies.
`default_nettype none

interface dpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb;

  modport source (output valid, argb, input ready);
  modport sink   (input valid, argb, output ready);
endinterface

`default_nettype wire

[hw/rtl/dpa_palette_ram.sv]
// Simple dual-port palette RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dpa_palette_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/dib_pixel_to_argb.sv]
// Top level: bitmap pixel (1/4/8/24/32 bpp) to ARGB8888 converter with palette.
// Depends on dpa_pkg, dpa_in_if, dpa_out_if and dpa_palette_ram.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          action, entry_index, pixel_data,
//                                      bit_position, mask_bit
//   out_ch   out  valid/ready          argb
//   APB      in   psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// One transaction per cycle unless out_ch stalls; a pixel's palette entry is read at its
// accept into the registered RAM output (stage s1), then the pixel moves to the output
// register, which drives out_ch. A load transaction writes the RAM and gives no result.
// rst_n is synchronous; it clears the pipeline valids and the config registers,
// not the palette. in_ch.ready is low during reset. A stalled output register
// still lets one more pixel sit in the read stage before in_ch.ready drops.
`default_nettype none

module dib_pixel_to_argb (
  input  logic                       clk,
  input  logic                       rst_n,
  dpa_in_if.sink                     in_ch,
  dpa_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpa_pkg::CFG_AW-1:0] paddr,
  input  logic [dpa_pkg::CFG_DW-1:0] pwdata,
  output logic [dpa_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import dpa_pkg::*;

  // ---------------- configuration registers ----------------
  logic [2:0] pixel_depth_r;
  logic       alpha_from_data_r;
  logic [8:0] palette_entries_r;
  logic       cfg_wr;
  cfg_reg_t   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_depth_r     <= RST_PIXEL_DEPTH;
      alpha_from_data_r <= RST_ALPHA_FROM_DATA;
      palette_entries_r <= RST_PALETTE_ENTRIES;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PIXEL_DEPTH:     pixel_depth_r     <= pwdata[2:0];
        REG_ALPHA_FROM_DATA: alpha_from_data_r <= pwdata[0];
        REG_PALETTE_ENTRIES: palette_entries_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PIXEL_DEPTH:     prdata = CFG_DW'(pixel_depth_r);
      REG_ALPHA_FROM_DATA: prdata = CFG_DW'(alpha_from_data_r);
      REG_PALETTE_ENTRIES: prdata = CFG_DW'(palette_entries_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // s1: palette read in flight (RAM output register holds the entry)
  // out: output register facing out_ch
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_acc;
  logic pix_acc;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_valid_r || s1_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pix_acc     = in_acc && (in_ch.action == ACT_PIXEL);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv)  s1_valid_nxt = 1'b0;
    if (pix_acc) s1_valid_nxt = 1'b1;

    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (s1_adv)       out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- pixel decode (accept cycle) ----------------
  logic [7:0]  pix_byte;
  logic [7:0]  pal_idx;
  logic [8:0]  full_sz;
  logic [8:0]  used_sz;
  logic        use_pal;
  logic        own_alpha;
  logic [7:0]  alpha;
  logic [PAL_AW-1:0] rd_addr;

  assign pix_byte = in_ch.pixel_data[7:0];

  always_comb begin
    use_pal   = 1'b1;
    own_alpha = 1'b0;
    pal_idx   = pix_byte;
    full_sz   = 9'd256;
    unique case (pix_depth_t'(pixel_depth_r))
      DEPTH_1BPP: begin
        // leftmost pixel in bit 7
        pal_idx = {7'd0, pix_byte[~in_ch.bit_position]};
        full_sz = 9'd2;
      end
      DEPTH_4BPP: begin
        // even column in the high nibble
        pal_idx = {4'd0, (in_ch.bit_position[0] ? pix_byte[3:0] : pix_byte[7:4])
                         & NIBBLE_MASK};
        full_sz = 9'd16;
      end
      DEPTH_24BPP: use_pal = 1'b0;
      DEPTH_32BPP: begin
        use_pal   = 1'b0;
        own_alpha = alpha_from_data_r;
      end
      default: ; // 8 bpp, also the unused codes
    endcase
  end

  assign used_sz = used_size(palette_entries_r, full_sz);
  // out-of-range index falls back to entry 0
  assign rd_addr = ({1'b0, pal_idx} < used_sz) ? pal_idx[PAL_AW-1:0] : '0;
  assign alpha   = own_alpha ? in_ch.pixel_data[31:24]
                 : (in_ch.mask_bit ? ALPHA_CLEAR : ALPHA_OPAQUE);

  // ---------------- palette memory ----------------
  logic              ram_we;
  logic [23:0]       ram_rdata;

  // loads past the store depth are dropped
  assign ram_we = in_acc && (in_ch.action == ACT_LOAD)
               && ({1'b0, in_ch.entry_index} < PAL_SIZE);

  dpa_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .WIDTH (24)
  ) u_pal (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.entry_index[PAL_AW-1:0]),
    .wdata (in_ch.pixel_data[23:0]),
    .re    (pix_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------- s1 side data ----------------
  // A write and a read never share a cycle, and a load lands before any later
  // read, so no bypass is needed. RAM output only moves on pix_acc, which
  // cannot happen while s1 is stuck.
  logic        s1_use_pal_r;
  logic [23:0] s1_rgb_r;
  logic [7:0]  s1_alpha_r;
  logic [31:0] out_argb_r;

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_use_pal_r <= use_pal;
      s1_rgb_r     <= in_ch.pixel_data[23:0];
      s1_alpha_r   <= alpha;
    end
    if (s1_adv) begin
      out_argb_r <= {s1_alpha_r, (s1_use_pal_r ? ram_rdata : s1_rgb_r)};
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.argb  = out_argb_r;

endmodule

`default_nettype wire

[hw/rtl/dpa_checker.sv]
// Port-level checker for dib_pixel_to_argb, attached by bind.
// Depends on dpa_pkg and dib_pixel_to_argb_macros.svh.
`default_nettype none
`include "dib_pixel_to_argb_macros.svh"

module dpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dpa_pkg::action_t    in_action,
  input logic                out_valid,
  input logic                out_ready,
  input logic [31:0]         out_argb,
  input logic                pready
);
  import dpa_pkg::*;

  `DPA_ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid, "out valid after reset")
  `DPA_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")
  `DPA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_argb), "stalled transaction changed")
  `DPA_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")
  `DPA_ASSERT(a_result_from_pixel, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready && in_action == ACT_PIXEL, 2), "result without pixel transaction")

endmodule

bind dib_pixel_to_argb dpa_checker u_dpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_argb  (out_ch.argb),
  .pready    (pready)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for dib_pixel_to_argb, palette loads and 1/4/8/24/32 bpp pixels.
// Depends on dpa_pkg, dpa_in_if, dpa_out_if and the dib_pixel_to_argb top level.

module tb_top;
  import dpa_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;       // loads give no result
  localparam int MAX_REPORTS  = 10;
  localparam int BATCH_ITEMS  = 17;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  dpa_in_if  in_if ();
  dpa_out_if out_if ();

  dib_pixel_to_argb u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: palette contents and the three config registers.
  logic [23:0] palette_shadow [PALETTE_DEPTH];
  logic [2:0]  depth_reg;
  logic        alpha_own_reg;
  logic [8:0]  entries_reg;

  // Expected ARGB words, oldest first.
  logic [31:0] argb_expected [$];

  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, argb_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver backpressure, re-rolled every cycle.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // ARGB word the block must produce for one pixel transaction under the
  // current register settings.
  function automatic logic [31:0] argb_of_pixel(input logic [31:0] data,
                                                input logic [2:0]  pos,
                                                input logic        mbit);
    logic [23:0] rgb;
    logic [7:0]  alpha;
    logic [7:0]  idx;
    logic [8:0]  full_sz;
    logic [8:0]  used;
    logic        own;
    own = 1'b0;
    if (depth_reg == DEPTH_24BPP || depth_reg == DEPTH_32BPP) begin
      rgb = data[23:0];
      own = (depth_reg == DEPTH_32BPP) && alpha_own_reg;
    end else begin
      case (depth_reg)
        DEPTH_1BPP: begin
          idx     = {7'd0, data[3'd7 - pos]};   // leftmost pixel is the MSB
          full_sz = 9'd2;
        end
        DEPTH_4BPP: begin
          idx     = {4'd0, pos[0] ? data[3:0] : data[7:4]};  // even column = high nibble
          full_sz = 9'd16;
        end
        default: begin                          // 8 bpp and the unused codes 5..7
          idx     = data[7:0];
          full_sz = 9'd256;
        end
      endcase
      used = entries_reg;
      if (used == 9'd0 || used > full_sz) used = full_sz;
      if (used > PAL_SIZE) used = PAL_SIZE;
      if ({1'b0, idx} >= used) idx = 8'd0;
      rgb = palette_shadow[idx];
    end
    if (own) alpha = data[31:24];
    else     alpha = mbit ? ALPHA_CLEAR : ALPHA_OPAQUE;
    return {alpha, rgb};
  endfunction

  function automatic void log_mismatch(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch (%s): expected argb %08h, got %08h", what, want, got);
  endfunction

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (argb_expected.size() == 0) begin
        log_mismatch("result with nothing expected", 32'h0, out_if.argb);
      end else begin
        want = argb_expected.pop_front();
        if (out_if.argb !== want) log_mismatch("argb", want, out_if.argb);
      end
    end
  end

  // One input transaction. While idling, valid is low and the payload is noise.
  // valid is left high after the accept so back-to-back items need no toggle.
  task automatic drive_transaction(input action_t     act,
                                   input logic [7:0]  idx,
                                   input logic [31:0] data,
                                   input logic [2:0]  pos,
                                   input logic        mbit);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid        <= 1'b0;
      in_if.action       <= action_t'($urandom_range(1));
      in_if.entry_index  <= 8'($urandom);
      in_if.pixel_data   <= $urandom;
      in_if.bit_position <= 3'($urandom);
      in_if.mask_bit     <= 1'($urandom);
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.entry_index  <= idx;
    in_if.pixel_data   <= data;
    in_if.bit_position <= pos;
    in_if.mask_bit     <= mbit;
    do @(posedge clk); while (!in_if.ready);
    if (act == ACT_LOAD) palette_shadow[idx] = data[23:0];
    else argb_expected = {argb_expected, argb_of_pixel(data, pos, mbit)};
  endtask

  // Drop valid, let every expected result arrive, then cover the load latency.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (argb_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; psel stays up so writes can chain.
  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_PIXEL_DEPTH:     depth_reg     = v[2:0];
      REG_ALPHA_FROM_DATA: alpha_own_reg = v[0];
      REG_PALETTE_ENTRIES: entries_reg   = v[8:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] depth, input logic own,
                            input logic [8:0] entries);
    wait_idle();
    write_reg(REG_PIXEL_DEPTH,     {29'd0, depth});
    write_reg(REG_ALPHA_FROM_DATA, {31'd0, own});
    write_reg(REG_PALETTE_ENTRIES, {23'd0, entries});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Every palette entry gets written once, so no pixel ever reads an
  // unwritten slot. Upper data byte is junk and must be dropped.
  task automatic test_palette_fill();
    for (int i = 0; i < PALETTE_DEPTH; i++)
      drive_transaction(ACT_LOAD, 8'(i), $urandom, 3'($urandom), 1'($urandom));
  endtask

  // 8, 1 and 4 bpp index extraction, mask alpha both ways.
  task automatic test_indexed_depths();
    set_config(DEPTH_8BPP, 1'b0, 9'd256);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_0000, 3'd0, 1'b0);
    drive_transaction(ACT_PIXEL, 8'hFF, 32'hFFFF_FFFF, 3'd7, 1'b1);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h5A5A_5A80, 3'd3, 1'b0);
    set_config(DEPTH_1BPP, 1'b0, 9'd256);
    for (int p = 0; p < 8; p++)
      drive_transaction(ACT_PIXEL, 8'h00, 32'hFFFF_FFA5, 3'(p), 1'(p));
    set_config(DEPTH_4BPP, 1'b0, 9'd256);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_003C, 3'd0, 1'b0);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_003C, 3'd1, 1'b1);
    drive_transaction(ACT_PIXEL, 8'h00, 32'hAAAA_AAF0, 3'd7, 1'b0);
  endtask

  // 24/32 bpp pass-through, own alpha on and off, unused depth codes as 8 bpp.
  task automatic test_direct_depths();
    set_config(DEPTH_24BPP, 1'b1, 9'd256);  // own alpha ignored at 24 bpp
    drive_transaction(ACT_PIXEL, 8'h00, 32'hFF12_3456, 3'd0, 1'b0);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h00AB_CDEF, 3'd5, 1'b1);
    set_config(DEPTH_32BPP, 1'b0, 9'd256);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h8011_2233, 3'd0, 1'b1);
    set_config(DEPTH_32BPP, 1'b1, 9'd256);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h8011_2233, 3'd0, 1'b1);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h00FF_FFFF, 3'd0, 1'b0);
    set_config(3'd5, 1'b1, 9'd256);
    drive_transaction(ACT_PIXEL, 8'h00, 32'hFFFF_FFC3, 3'd2, 1'b0);
    set_config(3'd7, 1'b0, 9'd256);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_00C3, 3'd6, 1'b1);
  endtask

  // Used palette size: limit, zero meaning full, above 2^bpp meaning full.
  task automatic test_palette_limit();
    set_config(DEPTH_8BPP, 1'b0, 9'd1);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_0001, 3'd0, 1'b0);
    set_config(DEPTH_8BPP, 1'b0, 9'd0);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_00FF, 3'd0, 1'b0);
    set_config(DEPTH_4BPP, 1'b0, 9'd3);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_0032, 3'd0, 1'b0);  // 3 -> 0
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_0032, 3'd1, 1'b0);  // 2 kept
    set_config(DEPTH_4BPP, 1'b0, 9'd511);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_00FF, 3'd0, 1'b1);
    set_config(DEPTH_1BPP, 1'b0, 9'd1);
    drive_transaction(ACT_PIXEL, 8'h00, 32'h0000_0080, 3'd0, 1'b0);
  endtask

  // Four idling phases, each with several register settings, the first of
  // each phase an extreme one. About a quarter of the items reload the palette.
  task automatic test_random_traffic();
    logic [8:0] entry_pick [12] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd15, 9'd16, 9'd17,
                                    9'd100, 9'd255, 9'd256, 9'd257, 9'd511};
    logic [2:0] depth;
    logic       own;
    logic [8:0] entries;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      for (int k = 0; k < 4; k++) begin
        if (k == 0) begin
          case (ph)
            0: begin depth = DEPTH_1BPP;  own = 1'b0; entries = 9'd1;   end
            1: begin depth = DEPTH_32BPP; own = 1'b1; entries = 9'd256; end
            2: begin depth = DEPTH_4BPP;  own = 1'b1; entries = 9'd511; end
            default: begin depth = DEPTH_8BPP; own = 1'b0; entries = 9'd0; end
          endcase
        end else begin
          depth   = 3'($urandom_range(7));
          own     = 1'($urandom);
          entries = ($urandom_range(1) == 0) ? entry_pick[$urandom_range(11)]
                                             : 9'($urandom);
        end
        set_config(depth, own, entries);
        for (int n = 0; n < BATCH_ITEMS; n++) begin
          drive_transaction(($urandom_range(3) == 0) ? ACT_LOAD : ACT_PIXEL,
                            8'($urandom), $urandom, 3'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  initial begin
    // Known values on every input before the first edge.
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_LOAD;
    in_if.entry_index  = 8'd0;
    in_if.pixel_data   = 32'd0;
    in_if.bit_position = 3'd0;
    in_if.mask_bit     = 1'b0;
    out_if.ready       = 1'b0;
    depth_reg          = RST_PIXEL_DEPTH;
    alpha_own_reg      = RST_ALPHA_FROM_DATA;
    entries_reg        = RST_PALETTE_ENTRIES;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (8 bpp, full palette) stay in force through the fill.
    test_palette_fill();
    test_indexed_depths();
    test_direct_depths();
    test_palette_limit();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
